// ===== sv/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg: shared types and constants for the Turing machine stepper
// Tape and rule table sizes, item and rule layouts, codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int TAPE_CELLS   = 1024;
  localparam int RULE_ENTRIES = 64;
  localparam int SYMBOL_BITS  = 8;

  localparam int TAPE_AW = $clog2(TAPE_CELLS);
  localparam int RULE_AW = $clog2(RULE_ENTRIES);
  localparam int RULE_CW = $clog2(RULE_ENTRIES + 1);

  localparam logic [SYMBOL_BITS-1:0] TAPE_BLANK = SYMBOL_BITS'(66);

  localparam logic [1:0] MOVE_RIGHT = 2'd1;
  localparam logic [1:0] MOVE_LEFT  = 2'd2;

  typedef enum logic [1:0] {
    ACT_RULE  = 2'd0,
    ACT_CELL  = 2'd1,
    ACT_START = 2'd2,
    ACT_STEP  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_STEPPED  = 3'd0,
    ST_HALTED   = 3'd1,
    ST_NO_RULE  = 3'd2,
    ST_OFF_TAPE = 3'd3,
    ST_LOADED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_START = 2'd0,
    CFG_END   = 2'd1,
    CFG_COUNT = 2'd2,
    CFG_BLANK = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC,
    FSM_SCAN,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic [7:0]             from_state;
    logic [SYMBOL_BITS-1:0] read_sym;
    logic [7:0]             to_state;
    logic [SYMBOL_BITS-1:0] write_sym;
    logic [1:0]             move;
  } rule_t;

  typedef struct packed {
    action_t                action;
    logic [5:0]             rule_slot;
    rule_t                  rule;
    logic [9:0]             cell_address;
    logic [SYMBOL_BITS-1:0] cell_symbol;
  } item_t;

  typedef struct packed {
    logic clear;
    logic load_item;
    logic exec;
    logic scan;
    logic out_load;
  } tms_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic step_scan;
    logic hit;
    logic last_rule;
  } tms_sts_t;

endpackage

// ===== sv/turing_machine_stepper_unit.sv =====
// ----------------------------------------------------------------------------
// turing_machine_stepper_unit: single-tape Turing machine stepper
// Load, cell write and start pass through the accept, execute and hand-off states;
// a step adds a search of k rules between execute and hand-off, k the rules examined (0 when halted or rule_count
// is 0, else 1 to rule_count, max 64), one rule table read per cycle.
// One transaction in flight; the next is accepted the cycle after hand-off.
// Reset: synchronous; a tape clear of all 1024 cells follows, input not ready then.
// ----------------------------------------------------------------------------
module turing_machine_stepper_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rule_slot, rule_from_state, rule_read_symbol, rule_to_state,
  // rule_write_symbol, rule_move, cell_address, cell_symbol
  input  logic [63:0] s_axis_tdata,
  // action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // machine_state, head_position, written_symbol, rule_hit
  output logic [31:0] m_axis_tdata,
  // status
  output logic [2:0]  m_axis_tuser
);
  import tms_pkg::*;

  item_t    item_in;
  tms_cmd_t cmd;
  tms_sts_t sts;
  status_t  out_status;
  logic [7:0] out_state;
  logic [9:0] out_head;
  logic [7:0] out_wsym;
  logic [5:0] out_hit;

  assign item_in.action               = action_t'(s_axis_tuser);
  assign item_in.rule_slot            = s_axis_tdata[5:0];
  assign item_in.rule.from_state      = s_axis_tdata[13:6];
  assign item_in.rule.read_sym        = s_axis_tdata[21:14];
  assign item_in.rule.to_state        = s_axis_tdata[29:22];
  assign item_in.rule.write_sym       = s_axis_tdata[37:30];
  assign item_in.rule.move            = s_axis_tdata[39:38];
  assign item_in.cell_address         = s_axis_tdata[49:40];
  assign item_in.cell_symbol          = s_axis_tdata[57:50];

  assign m_axis_tdata = {out_hit, out_wsym, out_head, out_state};
  assign m_axis_tuser = out_status;

  tms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tms_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_in    (item_in),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_status),
    .out_state  (out_state),
    .out_head   (out_head),
    .out_wsym   (out_wsym),
    .out_hit    (out_hit)
  );

endmodule

// ===== sv/tms_ctrl.sv =====
// ----------------------------------------------------------------------------
// tms_ctrl: sequencer for the Turing machine stepper
// Runs the tape clear after reset, takes one transaction at a time, walks
// the rule search and hands the result to the output register.
// ----------------------------------------------------------------------------
module tms_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  tms_pkg::tms_sts_t sts,
  output tms_pkg::tms_cmd_t cmd
);
  import tms_pkg::*;

  fsm_t state, state_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      FSM_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = FSM_IDLE;
      end
      FSM_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
        if (in_valid) state_next = FSM_EXEC;
      end
      FSM_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.step_scan ? FSM_SCAN : FSM_DONE;
      end
      FSM_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.last_rule) state_next = FSM_DONE;
      end
      FSM_DONE: begin
        cmd.out_load = out_free;
        if (out_free) state_next = FSM_IDLE;
      end
      default: state_next = FSM_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // a result only appears from the hand-off state
  a_rise_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == FSM_DONE))
    else $error("output valid rose outside hand-off");

endmodule

// ===== sv/tms_datapath.sv =====
// ----------------------------------------------------------------------------
// tms_datapath: tape, rule table and machine registers
// Holds configuration, the tape and rule memories, head and state, the
// sequential rule matcher and the output register.
// ----------------------------------------------------------------------------
module tms_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  input  tms_pkg::item_t         item_in,
  input  tms_pkg::tms_cmd_t      cmd,
  output tms_pkg::tms_sts_t      sts,
  output tms_pkg::status_t       out_status,
  output logic [7:0]             out_state,
  output logic [9:0]             out_head,
  output logic [7:0]             out_wsym,
  output logic [5:0]             out_hit
);
  import tms_pkg::*;

  logic [SYMBOL_BITS-1:0] tape_mem [TAPE_CELLS];
  rule_t                  rule_mem [RULE_ENTRIES];

  logic [7:0]             start_state;
  logic [7:0]             end_state;
  logic [6:0]             rule_count;
  logic [RULE_CW-1:0]     limit;

  item_t                  item;
  logic [TAPE_AW-1:0]     head;
  logic [7:0]             cur_state;
  logic [TAPE_AW-1:0]     clear_cnt;
  logic [RULE_CW-1:0]     scan_idx;
  logic [RULE_CW-1:0]     scan_idx_next;
  logic [RULE_AW-1:0]     rule_addr;
  rule_t                  rule_q;
  logic [SYMBOL_BITS-1:0] tape_q;

  status_t                res_status;
  logic [7:0]             res_wsym;
  logic [5:0]             res_hit;

  logic                   tape_we;
  logic [TAPE_AW-1:0]     tape_waddr;
  logic [SYMBOL_BITS-1:0] tape_wdata;
  logic                   halt_now;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_state <= 8'd0;
      end_state   <= 8'd1;
      rule_count  <= 7'd0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_START: start_state <= cfg_data;
        CFG_END:   end_state   <= cfg_data;
        CFG_COUNT: rule_count  <= cfg_data[6:0];
        CFG_BLANK: ;  // ignored; the reset fill uses the TAPE_BLANK constant
        default:   ;
      endcase
    end
  end

  assign limit = (rule_count > 7'(RULE_ENTRIES)) ? RULE_CW'(RULE_ENTRIES)
                                                 : RULE_CW'(rule_count);
  assign halt_now      = cur_state == end_state;
  assign scan_idx_next = scan_idx + RULE_CW'(1);
  assign rule_addr     = cmd.scan ? scan_idx_next[RULE_AW-1:0] : '0;

  assign sts.clear_last = clear_cnt == TAPE_AW'(TAPE_CELLS - 1);
  assign sts.step_scan  = (item.action == ACT_STEP) && !halt_now && (limit != '0);
  assign sts.hit        = (rule_q.from_state == cur_state) && (rule_q.read_sym == tape_q);
  assign sts.last_rule  = scan_idx_next == limit;

  always_ff @(posedge clk) begin
    if (cmd.load_item) item <= item_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_cnt <= '0;
    end else if (cmd.clear) begin
      clear_cnt <= clear_cnt + TAPE_AW'(1);
    end
  end

  // tape write port: reset fill, cell load, or the fired rule
  always_comb begin
    tape_we    = 1'b0;
    tape_waddr = head;
    tape_wdata = rule_q.write_sym;
    if (cmd.clear) begin
      tape_we    = 1'b1;
      tape_waddr = clear_cnt;
      tape_wdata = TAPE_BLANK;
    end else if (cmd.exec && item.action == ACT_CELL) begin
      tape_we    = 1'b1;
      tape_waddr = item.cell_address[TAPE_AW-1:0];
      tape_wdata = item.cell_symbol;
    end else if (cmd.scan && sts.hit) begin
      tape_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tape_we) tape_mem[tape_waddr] <= tape_wdata;
    tape_q <= tape_mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && item.action == ACT_RULE) begin
      rule_mem[item.rule_slot[RULE_AW-1:0]] <= item.rule;
    end
    rule_q <= rule_mem[rule_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= TAPE_AW'(1);
      cur_state <= 8'd0;
      scan_idx  <= '0;
    end else if (cmd.exec) begin
      scan_idx <= '0;
      if (item.action == ACT_START) begin
        head      <= TAPE_AW'(1);
        cur_state <= start_state;
      end
    end else if (cmd.scan) begin
      scan_idx <= scan_idx_next;
      if (sts.hit) begin
        cur_state <= rule_q.to_state;
        case (rule_q.move)
          MOVE_RIGHT: if (head != TAPE_AW'(TAPE_CELLS - 1)) head <= head + TAPE_AW'(1);
          MOVE_LEFT:  if (head != '0) head <= head - TAPE_AW'(1);
          default:    ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_wsym <= 8'd0;
      res_hit  <= 6'd0;
      if (item.action != ACT_STEP) begin
        res_status <= ST_LOADED;
      end else if (halt_now) begin
        res_status <= ST_HALTED;
      end else begin
        res_status <= ST_NO_RULE;
      end
    end else if (cmd.scan && sts.hit) begin
      res_wsym   <= rule_q.write_sym;
      res_hit    <= 6'(scan_idx);
      res_status <= ST_STEPPED;
      if ((rule_q.move == MOVE_RIGHT && head == TAPE_AW'(TAPE_CELLS - 1)) ||
          (rule_q.move == MOVE_LEFT && head == '0)) begin
        res_status <= ST_OFF_TAPE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_state  <= cur_state;
      out_head   <= 10'(head);
      out_wsym   <= res_wsym;
      out_hit    <= res_hit;
    end
  end

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !(cmd.exec || cmd.scan) |=> $stable(head) && $stable(cur_state))
    else $error("machine registers changed outside execution");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (scan_idx < limit))
    else $error("rule search ran past rule count");

  a_halt_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && item.action == ACT_STEP && halt_now |=> res_status == ST_HALTED)
    else $error("halted step did not report halt");

endmodule

// ===== tb/tb_turing_machine_stepper_unit.sv =====
// ----------------------------------------------------------------------------
// tb_turing_machine_stepper_unit: regression bench for the Turing machine stepper
// Drives rule loads, tape writes, starts and steps over the input stream.
// A scoreboard keeps its own copy of the tape, rule table, head and state,
// predicts the response to each accepted transaction and checks every
// returned transaction field by field, in order. Directed cases come first,
// then a full walk to the right tape end, then random programs and noise
// under varying sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_turing_machine_stepper_unit;
  import tms_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 80;
  localparam logic [1:0] MOVE_HOLD   = 2'd0;
  localparam logic [1:0] MOVE_UNUSED = 2'd3;

  typedef struct packed {
    status_t                status;
    logic [7:0]             mstate;
    logic [TAPE_AW-1:0]     head;
    logic [SYMBOL_BITS-1:0] wsym;
    logic [RULE_AW-1:0]     hit;
  } tm_result_t;

  class tm_scoreboard;
    logic [SYMBOL_BITS-1:0] tape [TAPE_CELLS];
    rule_t                  rules [RULE_ENTRIES];
    bit                     rule_loaded [RULE_ENTRIES];
    logic [TAPE_AW-1:0]     head;
    logic [7:0]             mstate;
    logic [7:0]             start_reg;
    logic [7:0]             end_reg;
    logic [6:0]             count_reg;
    tm_result_t             pending_results [$];
    int                     errors;

    function new();
      foreach (tape[i]) tape[i] = TAPE_BLANK;
      foreach (rule_loaded[i]) rule_loaded[i] = 1'b0;
      head = 1;
      mstate = 0;
      start_reg = 0;
      end_reg = 1;
      count_reg = 0;
      errors = 0;
    endfunction

    // blank symbol register has no effect in the design, so it is not tracked
    function void set_register(cfg_index_t idx, int value);
      case (idx)
        CFG_START: start_reg = 8'(value);
        CFG_END:   end_reg = 8'(value);
        CFG_COUNT: count_reg = 7'(value);
        default: ;
      endcase
    endfunction

    function void accept_item(item_t it);
      tm_result_t r;
      int lim;
      int i;
      bit fired;
      r = '0;
      r.status = ST_LOADED;
      fired = 1'b0;
      case (it.action)
        ACT_RULE: begin
          rules[it.rule_slot] = it.rule;
          rule_loaded[it.rule_slot] = 1'b1;
        end
        ACT_CELL: tape[it.cell_address] = it.cell_symbol;
        ACT_START: begin
          head = 1;
          mstate = start_reg;
        end
        default: begin
          if (mstate == end_reg) begin
            r.status = ST_HALTED;
          end else begin
            r.status = ST_NO_RULE;
            lim = (count_reg > RULE_ENTRIES) ? RULE_ENTRIES : int'(count_reg);
            for (i = 0; i < lim && !fired; i++) begin
              if (rules[i].from_state == mstate && rules[i].read_sym == tape[head]) begin
                fired = 1'b1;
                tape[head] = rules[i].write_sym;
                mstate = rules[i].to_state;
                r.status = ST_STEPPED;
                r.wsym = rules[i].write_sym;
                r.hit = RULE_AW'(i);
                if (rules[i].move == MOVE_RIGHT) begin
                  if (int'(head) + 1 >= TAPE_CELLS) r.status = ST_OFF_TAPE;
                  else head = head + 1'b1;
                end else if (rules[i].move == MOVE_LEFT) begin
                  if (head == 0) r.status = ST_OFF_TAPE;
                  else head = head - 1'b1;
                end
              end
            end
          end
        end
      endcase
      r.mstate = mstate;
      r.head = head;
      pending_results.push_back(r);
    endfunction

    function void check_result(tm_result_t got);
      tm_result_t want;
      bit bad;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected transaction: status %0d state %0d head %0d sym %0d rule %0d",
                   got.status, got.mstate, got.head, got.wsym, got.hit);
        return;
      end
      want = pending_results.pop_front();
      bad = (got.status !== want.status) || (got.mstate !== want.mstate) ||
            (got.head !== want.head) || (got.wsym !== want.wsym) || (got.hit !== want.hit);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $write("mismatch (exp/got): status %0d/%0d state %0d/%0d head %0d/%0d",
                 want.status, got.status, want.mstate, got.mstate, want.head, got.head);
          $display(" sym %0d/%0d rule %0d/%0d", want.wsym, got.wsym, want.hit, got.hit);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_START;
  logic [7:0]  cfg_data = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // rule_slot, rule_from_state, rule_read_symbol, rule_to_state,
  // rule_write_symbol, rule_move, cell_address, cell_symbol
  logic [63:0] s_axis_tdata = 64'd0;
  // action
  logic [1:0]  s_axis_tuser = ACT_RULE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // machine_state, head_position, written_symbol, rule_hit
  logic [31:0] m_axis_tdata;
  // status
  logic [2:0]  m_axis_tuser;

  tm_scoreboard sb;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_request = 1'b0;
  int          hold_left = 0;
  int          items_sent = 0;
  int unsigned cycles = 0;

  turing_machine_stepper_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("turing_machine_stepper_unit regression: fail");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = 400;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    tm_result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status = status_t'(m_axis_tuser);
      got.mstate = m_axis_tdata[7:0];
      got.head = m_axis_tdata[17:8];
      got.wsym = m_axis_tdata[25:18];
      got.hit = m_axis_tdata[31:26];
      sb.check_result(got);
    end
  end

  function automatic item_t random_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(item_t)-1:0];
  endfunction

  function automatic item_t make_rule(input int slot, input int src_state, input int rd_sym,
                                      input int dst_state, input int wr_sym, input int mv);
    item_t it;
    it = random_item();
    it.action = ACT_RULE;
    it.rule_slot = 6'(slot);
    it.rule.from_state = 8'(src_state);
    it.rule.read_sym = SYMBOL_BITS'(rd_sym);
    it.rule.to_state = 8'(dst_state);
    it.rule.write_sym = SYMBOL_BITS'(wr_sym);
    it.rule.move = 2'(mv);
    return it;
  endfunction

  function automatic item_t make_cell(input int addr, input int sym);
    item_t it;
    it = random_item();
    it.action = ACT_CELL;
    it.cell_address = 10'(addr);
    it.cell_symbol = SYMBOL_BITS'(sym);
    return it;
  endfunction

  function automatic item_t make_ctl(input action_t act);
    item_t it;
    it = random_item();
    it.action = act;
    return it;
  endfunction

  function automatic int pick_byte();
    case ($urandom_range(7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 71; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 71; end
      default: begin send_idle_pct = 18; stall_pct = 18; end
    endcase
  endtask

  task automatic drive_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      s_axis_tdata = {$urandom, $urandom};
      s_axis_tuser = 2'($urandom);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'd0, it.cell_symbol, it.cell_address, it.rule.move, it.rule.write_sym,
                    it.rule.to_state, it.rule.read_sym, it.rule.from_state, it.rule_slot};
    s_axis_tuser = it.action;
    do @(posedge clk); while (!s_axis_tready);
    sb.accept_item(it);
    items_sent++;
  endtask

  // a step must never search a rule entry that was never loaded
  task automatic send_item(input item_t it);
    int lim;
    int i;
    if (it.action == ACT_STEP) begin
      lim = (sb.count_reg > RULE_ENTRIES) ? RULE_ENTRIES : int'(sb.count_reg);
      for (i = 0; i < lim; i++)
        if (!sb.rule_loaded[i])
          drive_item(make_rule(i, $urandom, $urandom, $urandom, $urandom, $urandom_range(3)));
    end
    drive_item(it);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = 8'(value);
    sb.set_register(idx, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_registers(input int st, input int en, input int cnt, input int blank);
    write_reg(CFG_START, st);
    write_reg(CFG_END, en);
    write_reg(CFG_COUNT, cnt);
    write_reg(CFG_BLANK, blank);
  endtask

  task automatic run_program_phase(input int ph);
    logic [7:0] st [4];
    logic [7:0] sy [3];
    logic [1:0] mv;
    int k;
    int kw;
    int i;
    set_idle_mode(ph % 4);
    wait_idle();
    st[0] = 8'(pick_byte());
    st[1] = 8'($urandom);
    st[2] = 8'($urandom);
    st[3] = ($urandom_range(9) == 0) ? st[0] : 8'(pick_byte());
    case ($urandom_range(9))
      0: k = 0;
      1: k = 1;
      2: k = RULE_ENTRIES;
      3: k = 127;
      default: k = $urandom_range(2, 12);
    endcase
    program_registers(st[0], st[3], k, pick_byte());
    kw = (k < 16) ? k : 16;
    sy[0] = sb.tape[1];
    sy[1] = 8'(pick_byte());
    sy[2] = 8'($urandom);
    for (i = 0; i < kw; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: mv = MOVE_RIGHT;
        4, 5, 6, 7: mv = MOVE_LEFT;
        8: mv = MOVE_HOLD;
        default: mv = MOVE_UNUSED;
      endcase
      send_item(make_rule(i, st[$urandom_range(2)], sy[$urandom_range(2)],
                          st[$urandom_range(3)], sy[$urandom_range(2)], mv));
    end
    repeat ($urandom_range(3)) send_item(make_cell($urandom_range(6), sy[$urandom_range(2)]));
    send_item(make_ctl(ACT_START));
    if (ph == 2) hold_request = 1'b1;
    repeat ($urandom_range(8, 30)) begin
      case ($urandom_range(19))
        0: send_item(random_item());
        1: send_item(make_ctl(ACT_START));
        default: send_item(make_ctl(ACT_STEP));
      endcase
    end
  endtask

  task automatic run_noise_phase(input int ph);
    set_idle_mode(ph % 4);
    wait_idle();
    program_registers(pick_byte(), pick_byte(), $urandom_range(127), pick_byte());
    repeat (30) send_item(random_item());
  endtask

  initial begin
    logic [7:0] run_syms [$];
    bit         seen [256];
    logic [7:0] run_state;
    int         a;
    int         ph;
    sb = new();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    set_idle_mode(0);

    // reset registers: no rules searched
    send_item(make_ctl(ACT_STEP));
    send_item(make_rule(0, 0, TAPE_BLANK, 5, 255, MOVE_RIGHT));
    send_item(make_rule(63, 255, 0, 0, 0, MOVE_LEFT));
    send_item(make_rule(1, 5, 0, 1, 8'hAA, MOVE_UNUSED));
    send_item(make_rule(2, 5, TAPE_BLANK, 7, 1, MOVE_LEFT));
    send_item(make_cell(1023, 255));
    send_item(make_cell(0, 0));
    send_item(make_cell(2, 0));
    send_item(make_ctl(ACT_START));
    wait_idle();
    program_registers(0, 1, 3, TAPE_BLANK);
    // fire, fire with odd move code, halt twice, restart, fire, fall off the left end, then find no rule
    send_item(make_ctl(ACT_STEP));
    send_item(make_ctl(ACT_STEP));
    send_item(make_ctl(ACT_STEP));
    send_item(make_ctl(ACT_STEP));
    send_item(make_ctl(ACT_START));
    send_item(make_rule(1, 0, 255, 6, 3, MOVE_LEFT));
    send_item(make_rule(2, 6, 0, 8, 9, MOVE_LEFT));
    send_item(make_ctl(ACT_STEP));
    send_item(make_ctl(ACT_STEP));
    send_item(make_ctl(ACT_STEP));

    // walk right across the whole tape until the head would leave it
    wait_idle();
    for (a = 1; a < TAPE_CELLS; a++) begin
      if (!seen[sb.tape[a]]) begin
        seen[sb.tape[a]] = 1'b1;
        run_syms.push_back(sb.tape[a]);
      end
    end
    run_state = 8'($urandom);
    program_registers(run_state, run_state + 8'd1, run_syms.size(), $urandom_range(255));
    foreach (run_syms[i])
      send_item(make_rule(i, run_state, run_syms[i], run_state, run_syms[i], MOVE_RIGHT));
    send_item(make_ctl(ACT_START));
    repeat (TAPE_CELLS) send_item(make_ctl(ACT_STEP));

    ph = 0;
    while (ph < 5) begin
      if (ph % 5 == 4) run_noise_phase(ph);
      else run_program_phase(ph);
      ph++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("turing_machine_stepper_unit regression: pass");
    end else begin
      $display("turing_machine_stepper_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/tms_pkg.sv
sv/tms_ctrl.sv
sv/tms_datapath.sv
sv/turing_machine_stepper_unit.sv
tb/tb_turing_machine_stepper_unit.sv
